[hw/rtl/mtf_pkg.sv]
// Shared types, constants and codes for the mutex table with FIFO handoff.
// Used by every module of the block; depends on nothing.
package mtf_pkg;

   // Sizes of the tables.
   localparam int NUM_MUTEX = 32;
   localparam int NUM_TASKS = 64;

   // Fixed field widths of the command and response.
   localparam int CMD_W    = 2;
   localparam int ID_W     = 6;
   localparam int STATUS_W = 2;

   // Index widths that follow from the table sizes.
   localparam int MUTEX_IDX_W = (NUM_MUTEX > 1) ? $clog2(NUM_MUTEX) : 1;
   localparam int TASK_IDX_W  = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   // Free-slot search: groups of eight, one registered result per group.
   localparam int GRP_SIZE  = 8;
   localparam int GRP_IDX_W = 3;
   localparam int NUM_GRP   = (NUM_MUTEX + GRP_SIZE - 1) / GRP_SIZE;

   // Command codes on the request port.
   localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

   // Status codes on the response port.
   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOMEM     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_OWNER = 2'd3;

   // Operation class decided by the front end.
   typedef enum logic [1:0] {
      OP_CREATE,
      OP_LOCK,
      OP_UNLOCK,
      OP_INVALID
   } op_type;

   // One classified request as held in the hand-off queue.
   typedef struct packed {
      op_type                  op;
      logic [MUTEX_IDX_W-1:0]  mutex;
      logic [ID_W-1:0]         task_id;
   } entry_type;

   // Head of the hand-off queue as seen by the back end.
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } qhead_type;

   // Response as produced by the back end.
   typedef struct packed {
      logic                valid;
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     handle;
      logic                must_wait;
      logic                woken_valid;
      logic [ID_W-1:0]     woken_task;
   } rsp_type;

   // Back-end sequencer states.
   typedef enum logic {
      BK_READ,
      BK_WRITE
   } back_state_type;

endpackage

[hw/rtl/mtf_front.sv]
// Front end: accepts requests and classifies them before queueing.
// Depends on mtf_pkg.
module mtf_front (
   input  logic                        start,
   input  logic                        queue_full,
   input  logic [mtf_pkg::CMD_W-1:0]   req_command,
   input  logic [mtf_pkg::ID_W-1:0]    req_mutex_id,
   input  logic [mtf_pkg::ID_W-1:0]    req_task_id,
   output logic                        push,
   output mtf_pkg::entry_type          push_entry
);

   logic ids_ok;

   // A request is taken whenever the queue has room.
   assign push = start && !queue_full;

   // Both ids must lie inside their tables for lock and unlock.
   assign ids_ok = (req_mutex_id < mtf_pkg::ID_W'(mtf_pkg::NUM_MUTEX))
                && ({1'b0, req_task_id} < (mtf_pkg::ID_W + 1)'(mtf_pkg::NUM_TASKS));

   // Sort the request into one of the operation classes.
   always_comb begin
      push_entry.mutex   = req_mutex_id[mtf_pkg::MUTEX_IDX_W-1:0];
      push_entry.task_id = req_task_id;
      case (req_command)
         mtf_pkg::CMD_CREATE: push_entry.op = mtf_pkg::OP_CREATE;
         mtf_pkg::CMD_LOCK:   push_entry.op = ids_ok ? mtf_pkg::OP_LOCK : mtf_pkg::OP_INVALID;
         mtf_pkg::CMD_UNLOCK: push_entry.op = ids_ok ? mtf_pkg::OP_UNLOCK : mtf_pkg::OP_INVALID;
         default:             push_entry.op = mtf_pkg::OP_INVALID;
      endcase
   end

endmodule

[hw/rtl/mtf_queue.sv]
// Two-entry hand-off queue between the front end and the back end.
// Depends on mtf_pkg.
module mtf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mtf_pkg::entry_type push_entry,
   input  logic               pop,
   output mtf_pkg::qhead_type head,
   output logic               full
);

   mtf_pkg::entry_type slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == 2'd2);
   assign head.valid = (count_ff != 2'd0);
   assign head.entry = slot_ff[rd_ptr_ff];

endmodule

[hw/rtl/mtf_back.sv]
// Back end: mutex tables, wait-queue links and the two-step update sequencer.
// Depends on mtf_pkg; fed by mtf_queue.
module mtf_back (
   input  logic               clock,
   input  logic               reset,
   input  mtf_pkg::qhead_type head,
   output logic               pop,
   output mtf_pkg::rsp_type   rsp
);

   mtf_pkg::back_state_type state_ff, state_in;
   logic exec;

   // Per-mutex flags.
   logic [mtf_pkg::NUM_MUTEX-1:0] alloc_ff, alloc_in;
   logic [mtf_pkg::NUM_MUTEX-1:0] held_ff, held_in;
   logic [mtf_pkg::NUM_MUTEX-1:0] qne_ff, qne_in;

   // Per-mutex holder and queue ends; per-task link memory.
   logic [mtf_pkg::ID_W-1:0] holder_ff [mtf_pkg::NUM_MUTEX];
   logic [mtf_pkg::ID_W-1:0] head_ff   [mtf_pkg::NUM_MUTEX];
   logic [mtf_pkg::ID_W-1:0] tail_ff   [mtf_pkg::NUM_MUTEX];
   logic [mtf_pkg::ID_W-1:0] link_mem  [mtf_pkg::NUM_TASKS];
   logic [mtf_pkg::ID_W-1:0] link_rd_ff;

   // Registered level of the free-slot search.
   logic [mtf_pkg::NUM_GRP-1:0]   grp_found_ff, grp_found_in;
   logic [mtf_pkg::GRP_IDX_W-1:0] grp_idx_ff [mtf_pkg::NUM_GRP];
   logic [mtf_pkg::GRP_IDX_W-1:0] grp_idx_in [mtf_pkg::NUM_GRP];

   // Write controls produced by the update step.
   logic                               holder_we, head_we, tail_we, link_we;
   logic [mtf_pkg::ID_W-1:0]           holder_wd, head_wd;
   logic [mtf_pkg::TASK_IDX_W-1:0]     link_addr;
   logic                               free_found;
   logic [mtf_pkg::ID_W-1:0]           free_sel;
   logic [mtf_pkg::MUTEX_IDX_W-1:0]    m;
   logic [mtf_pkg::ID_W-1:0]           t;
   mtf_pkg::rsp_type                   rsp_ff, rsp_in;

   assign m = head.entry.mutex;
   assign t = head.entry.task_id;

   // Sequencer next state: a read step, then an update step.
   always_comb begin
      case (state_ff)
         mtf_pkg::BK_READ:  state_in = head.valid ? mtf_pkg::BK_WRITE : mtf_pkg::BK_READ;
         mtf_pkg::BK_WRITE: state_in = mtf_pkg::BK_READ;
         default:           state_in = mtf_pkg::BK_READ;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      case (state_ff)
         mtf_pkg::BK_WRITE: exec = 1'b1;
         default:           exec = 1'b0;
      endcase
   end

   assign pop = exec;

   // First level of the lowest-free search, one result per group of eight.
   always_comb begin
      logic [mtf_pkg::NUM_GRP*mtf_pkg::GRP_SIZE-1:0] free_pad;
      free_pad = '0;
      free_pad[mtf_pkg::NUM_MUTEX-1:0] = ~alloc_ff;
      for (int g = 0; g < mtf_pkg::NUM_GRP; g++) begin
         grp_found_in[g] = 1'b0;
         grp_idx_in[g]   = '0;
         for (int b = mtf_pkg::GRP_SIZE - 1; b >= 0; b--) begin
            if (free_pad[g*mtf_pkg::GRP_SIZE + b]) begin
               grp_found_in[g] = 1'b1;
               grp_idx_in[g]   = mtf_pkg::GRP_IDX_W'(b);
            end
         end
      end
   end

   // Second level: the lowest group that has a free slot.
   always_comb begin
      free_found = 1'b0;
      free_sel   = '0;
      for (int g = mtf_pkg::NUM_GRP - 1; g >= 0; g--) begin
         if (grp_found_ff[g]) begin
            free_found = 1'b1;
            free_sel   = mtf_pkg::ID_W'(g * mtf_pkg::GRP_SIZE)
                       | mtf_pkg::ID_W'(grp_idx_ff[g]);
         end
      end
   end

   // Update step: carry out the request against the tables.
   always_comb begin
      alloc_in  = alloc_ff;
      held_in   = held_ff;
      qne_in    = qne_ff;
      holder_we = 1'b0;
      holder_wd = t;
      head_we   = 1'b0;
      head_wd   = t;
      tail_we   = 1'b0;
      link_we   = 1'b0;
      link_addr = tail_ff[m][mtf_pkg::TASK_IDX_W-1:0];
      rsp_in             = '0;
      rsp_in.valid       = exec;
      rsp_in.status      = mtf_pkg::ST_OK;
      if (exec) begin
         case (head.entry.op)
            mtf_pkg::OP_CREATE: begin
               if (free_found) begin
                  alloc_in[free_sel[mtf_pkg::MUTEX_IDX_W-1:0]] = 1'b1;
                  rsp_in.handle = free_sel;
               end else begin
                  rsp_in.status = mtf_pkg::ST_NOMEM;
               end
            end
            mtf_pkg::OP_LOCK: begin
               if (!alloc_ff[m]) begin
                  rsp_in.status = mtf_pkg::ST_INVALID;
               end else if (held_ff[m]) begin
                  // Busy: append the caller to the wait queue.
                  rsp_in.must_wait = 1'b1;
                  tail_we          = 1'b1;
                  if (qne_ff[m]) begin
                     link_we = 1'b1;
                  end else begin
                     head_we   = 1'b1;
                     qne_in[m] = 1'b1;
                  end
               end else begin
                  held_in[m] = 1'b1;
                  holder_we  = 1'b1;
               end
            end
            mtf_pkg::OP_UNLOCK: begin
               if (!alloc_ff[m]) begin
                  rsp_in.status = mtf_pkg::ST_INVALID;
               end else if (!held_ff[m] || holder_ff[m] != t) begin
                  rsp_in.status = mtf_pkg::ST_NOT_OWNER;
               end else if (qne_ff[m]) begin
                  // Hand the mutex straight to the head waiter.
                  holder_we          = 1'b1;
                  holder_wd          = head_ff[m];
                  rsp_in.woken_valid = 1'b1;
                  rsp_in.woken_task  = head_ff[m];
                  if (head_ff[m] == tail_ff[m]) begin
                     qne_in[m] = 1'b0;
                  end else begin
                     head_we = 1'b1;
                     head_wd = link_rd_ff;
                  end
               end else begin
                  held_in[m] = 1'b0;
                  holder_we  = 1'b1;
                  holder_wd  = '0;
               end
            end
            default: begin
               rsp_in.status = mtf_pkg::ST_INVALID;
            end
         endcase
      end
   end

   // Control state and tables with a defined reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mtf_pkg::BK_READ;
         alloc_ff     <= '0;
         held_ff      <= '0;
         qne_ff       <= '0;
         rsp_ff.valid <= 1'b0;
         for (int i = 0; i < mtf_pkg::NUM_MUTEX; i++) begin
            holder_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         alloc_ff <= alloc_in;
         held_ff  <= held_in;
         qne_ff   <= qne_in;
         rsp_ff   <= rsp_in;
         if (holder_we) begin
            holder_ff[m] <= holder_wd;
         end
      end
   end

   // Queue ends and search results are defined before they are read.
   always_ff @(posedge clock) begin
      grp_found_ff <= grp_found_in;
      for (int g = 0; g < mtf_pkg::NUM_GRP; g++) begin
         grp_idx_ff[g] <= grp_idx_in[g];
      end
      if (head_we) begin
         head_ff[m] <= head_wd;
      end
      if (tail_we) begin
         tail_ff[m] <= t;
      end
   end

   // Link memory: one write port, one registered read port at the queue head.
   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_addr] <= t;
      end
      link_rd_ff <= link_mem[head_ff[m][mtf_pkg::TASK_IDX_W-1:0]];
   end

   assign rsp = rsp_ff;

endmodule

[hw/rtl/mutex_table_fifo_handoff.sv]
// Top level of the mutex table with FIFO wait queues and direct handoff.
// Depends on mtf_pkg, mtf_front, mtf_queue and mtf_back.
//
//   Channel   Handshake                 Payload
//   request   start in, busy out        req_command, req_mutex_id, req_task_id
//   response  rsp_valid out (strobe)    rsp_status, rsp_handle, rsp_must_wait,
//                                       rsp_woken_valid, rsp_woken_task
//
// Each request holds the back end for a read step for the link memory and
// the free-slot search, then an update step; the strobe comes from a register
// loaded by the update step. A two-entry queue lets the front take requests
// while the back end works; busy is high in reset and whenever that queue is
// full. Synchronous reset clears all mutexes at once. Responses cannot be
// stalled and are shown for exactly one cycle.
module mutex_table_fifo_handoff (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mtf_pkg::CMD_W-1:0]     req_command,
   input  logic [mtf_pkg::ID_W-1:0]      req_mutex_id,
   input  logic [mtf_pkg::ID_W-1:0]      req_task_id,
   output logic                          rsp_valid,
   output logic [mtf_pkg::STATUS_W-1:0]  rsp_status,
   output logic [mtf_pkg::ID_W-1:0]      rsp_handle,
   output logic                          rsp_must_wait,
   output logic                          rsp_woken_valid,
   output logic [mtf_pkg::ID_W-1:0]      rsp_woken_task
);

   logic               push;
   logic               pop;
   logic               queue_full;
   mtf_pkg::entry_type push_entry;
   mtf_pkg::qhead_type qhead;
   mtf_pkg::rsp_type   rsp;

   // Request classification.
   mtf_front u_front (
      .start        (start),
      .queue_full   (queue_full),
      .req_command  (req_command),
      .req_mutex_id (req_mutex_id),
      .req_task_id  (req_task_id),
      .push         (push),
      .push_entry   (push_entry)
   );

   // Hand-off queue.
   mtf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (qhead),
      .full       (queue_full)
   );

   // Table update engine.
   mtf_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (qhead),
      .pop   (pop),
      .rsp   (rsp)
   );

   assign busy            = queue_full || reset;
   assign rsp_valid       = rsp.valid;
   assign rsp_status      = rsp.status;
   assign rsp_handle      = rsp.handle;
   assign rsp_must_wait   = rsp.must_wait;
   assign rsp_woken_valid = rsp.woken_valid;
   assign rsp_woken_task  = rsp.woken_task;

endmodule

[hw/rtl/mtf_checker.sv]
// Port-level checks for the mutex table with FIFO handoff, bound to the top.
// Depends on mtf_pkg and mutex_table_fifo_handoff.
module mtf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic [mtf_pkg::CMD_W-1:0]     req_command,
   input logic [mtf_pkg::ID_W-1:0]      req_mutex_id,
   input logic [mtf_pkg::ID_W-1:0]      req_task_id,
   input logic                          rsp_valid,
   input logic [mtf_pkg::STATUS_W-1:0]  rsp_status,
   input logic [mtf_pkg::ID_W-1:0]      rsp_handle,
   input logic                          rsp_must_wait,
   input logic                          rsp_woken_valid,
   input logic [mtf_pkg::ID_W-1:0]      rsp_woken_task
);

   // No response may follow directly out of reset.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response strobe right after reset");

   // Each request passes a read step before its update step, so strobes never come back to back.
   a_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses in consecutive cycles");

   // A queued caller is never also a handoff.
   a_wait_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_must_wait |-> rsp_status == mtf_pkg::ST_OK && !rsp_woken_valid)
      else $error("must_wait with error or wake-up");

   // A failed request carries no handle, wait or wake-up.
   a_fail_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != mtf_pkg::ST_OK
      |-> rsp_handle == '0 && !rsp_must_wait && !rsp_woken_valid && rsp_woken_task == '0)
      else $error("failed response with payload");

endmodule

bind mutex_table_fifo_handoff mtf_checker u_checker (.*);
